// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property sampled on the rising clock edge, switched off while reset is low.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Same-cycle implication built on the form above.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  `ASSERT_RST(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ----- hw/rtl/mbps_pkg.sv -----
// ----------------------------------------------------------------------------
// Masked byte pattern scanner package
// Shared constants, register indexes and types of the scanner.
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int unsigned MaxPattern = 32;
  localparam int unsigned LenW       = 6;
  localparam int unsigned PosW       = $clog2(MaxPattern);
  localparam int unsigned CntW       = 32;
  localparam int unsigned CfgIdxW    = 4;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned PatWords   = MaxPattern / 8;
  localparam int unsigned OutDataW   = 72;

  localparam logic [CntW-1:0] NoHint = '1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBase     = 4'd0,
    CfgLength   = 4'd1,
    CfgWildcard = 4'd2,
    CfgHint     = 4'd3,
    CfgPattern0 = 4'd4,
    CfgPattern1 = 4'd5,
    CfgPattern2 = 4'd6,
    CfgPattern3 = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] pat;
    logic       wild;
  } cell_ref_t;

endpackage

// ----- hw/rtl/mbps_cell.sv -----
// ----------------------------------------------------------------------------
// Scanner window cell
// Holds one window byte, passes it on to the next cell on every shift and
// compares it with the pattern byte aligned to its place.
// ----------------------------------------------------------------------------
module mbps_cell (
  input  logic                clk_i,
  input  logic                shift_i,
  input  logic [7:0]          byte_i,
  input  mbps_pkg::cell_ref_t ref_i,
  output logic [7:0]          byte_o,
  output logic                ok_o
);

  logic [7:0] byte_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;
  assign ok_o   = ref_i.wild || (byte_q == ref_i.pat);

endmodule

// ----- hw/rtl/masked_byte_pattern_scanner_unit.sv -----
// ----------------------------------------------------------------------------
// Masked byte pattern scanner
// Scans an image byte stream for a pattern with wildcard bytes and reports
// the hint or first match at the end of each image.
// ----------------------------------------------------------------------------
// The scanner takes one image byte per clock cycle while s_tready is high. Each byte
// shifts into a row of 32 window cells, and every cell compares its byte with
// the pattern byte aligned to it, so each window position is checked in the
// cycle after its last byte arrives. The result for the tlast byte passes
// through the result and output registers. s_tready drops only while a final
// byte waits behind two result words that the sink has not yet taken.
module masked_byte_pattern_scanner_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mbps_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [mbps_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // image_byte
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // found, match_address, hint_correct, first_match_offset, zero padding
  output logic [mbps_pkg::OutDataW-1:0]    m_tdata
);

  import mbps_pkg::*;

  logic [CntW-1:0]                  base_q;
  logic [LenW-1:0]                  plen_q;
  logic [MaxPattern-1:0]            mask_q;
  logic [CntW-1:0]                  hint_q;
  logic [PatWords-1:0][CfgDataW-1:0] pat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      plen_q <= LenW'(1);
      mask_q <= '0;
      hint_q <= NoHint;
      pat_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgBase:     base_q   <= cfg_data_i[CntW-1:0];
        CfgLength:   plen_q   <= cfg_data_i[LenW-1:0];
        CfgWildcard: mask_q   <= cfg_data_i[MaxPattern-1:0];
        CfgHint:     hint_q   <= cfg_data_i[CntW-1:0];
        CfgPattern0: pat_q[0] <= cfg_data_i;
        CfgPattern1: pat_q[1] <= cfg_data_i;
        CfgPattern2: pat_q[2] <= cfg_data_i;
        CfgPattern3: pat_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [LenW-1:0] n_used;

  always_comb begin
    if (plen_q == '0) begin
      n_used = LenW'(1);
    end else if (plen_q > LenW'(MaxPattern)) begin
      n_used = LenW'(MaxPattern);
    end else begin
      n_used = plen_q;
    end
  end

  // Cell k holds the byte received k words ago and needs pattern byte n-1-k.
  // Reversing the pattern and shifting it down by MaxPattern-n lines it up.
  logic [PosW-1:0]           align_sh;
  logic [8*MaxPattern-1:0]   rev_pat;
  logic [MaxPattern-1:0]     rev_mask;
  logic [8*MaxPattern-1:0]   al_pat_q;
  logic [MaxPattern-1:0]     al_wild_q;
  logic [2*MaxPattern-1:0]   wild_ext;

  assign align_sh = PosW'(LenW'(MaxPattern) - n_used);

  always_comb begin
    for (int i = 0; i < MaxPattern; i++) begin
      rev_pat[8*i +: 8] = pat_q[(MaxPattern-1-i)/8][8*((MaxPattern-1-i)%8) +: 8];
      rev_mask[i]       = mask_q[MaxPattern-1-i];
    end
  end

  assign wild_ext = {{MaxPattern{1'b1}}, rev_mask} >> align_sh;

  always_ff @(posedge clk_i) begin
    al_pat_q  <= rev_pat >> {align_sh, 3'b000};
    al_wild_q <= wild_ext[MaxPattern-1:0];
  end

  logic            a_valid_q, a_last_q, a_chk_q;
  logic [CntW-1:0] a_off_q, seen_q, seen_inc;
  logic            a_move, acc, sat, shift_en, r_free, out_free;

  assign a_move   = !a_valid_q || !a_last_q || r_free;
  assign s_tready = a_move;
  assign acc      = s_tvalid && a_move;
  assign sat      = (seen_q == '1);
  assign seen_inc = seen_q + CntW'(1);
  assign shift_en = acc && !sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      a_last_q  <= 1'b0;
      a_chk_q   <= 1'b0;
      a_off_q   <= '0;
      seen_q    <= '0;
    end else begin
      if (a_move) begin
        a_valid_q <= acc;
        a_last_q  <= s_tlast;
        a_chk_q   <= !sat && (seen_inc >= CntW'(n_used));
        a_off_q   <= seen_inc - CntW'(n_used);
      end
      if (acc) begin
        if (s_tlast) begin
          seen_q <= '0;
        end else if (!sat) begin
          seen_q <= seen_inc;
        end
      end
    end
  end

  logic [MaxPattern-1:0][7:0] win;
  logic [MaxPattern-1:0]      cell_ok;

  for (genvar k = 0; k < MaxPattern; k++) begin : g_cell
    cell_ref_t  cref;
    logic [7:0] cin;
    assign cref.pat  = al_pat_q[8*k +: 8];
    assign cref.wild = al_wild_q[k];
    if (k == 0) begin : g_head
      assign cin = s_tdata;
    end else begin : g_link
      assign cin = win[k-1];
    end
    mbps_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift_en),
      .byte_i  (cin),
      .ref_i   (cref),
      .byte_o  (win[k]),
      .ok_o    (cell_ok[k])
    );
  end

  logic            match, b_fire, pos_hit, hit_now;
  logic            hit_q, any_q, hit_nx, any_nx;
  logic [CntW-1:0] early_q, early_nx;

  assign match    = &cell_ok;
  assign b_fire   = a_valid_q && a_move;
  assign pos_hit  = a_chk_q && match;
  assign hit_now  = pos_hit && (hint_q != NoHint) && (a_off_q == hint_q);
  assign hit_nx   = hit_q || hit_now;
  assign any_nx   = any_q || pos_hit;
  assign early_nx = (pos_hit && !any_q) ? a_off_q : early_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q   <= 1'b0;
      any_q   <= 1'b0;
      early_q <= '0;
    end else if (b_fire) begin
      if (a_last_q) begin
        hit_q   <= 1'b0;
        any_q   <= 1'b0;
        early_q <= '0;
      end else begin
        hit_q   <= hit_nx;
        any_q   <= any_nx;
        early_q <= early_nx;
      end
    end
  end

  logic            r_valid_q, r_hit_q, r_any_q;
  logic [CntW-1:0] r_off_q;

  assign r_free = !r_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
      r_hit_q   <= 1'b0;
      r_any_q   <= 1'b0;
      r_off_q   <= '0;
    end else if (r_free) begin
      r_valid_q <= b_fire && a_last_q;
      if (b_fire && a_last_q) begin
        r_hit_q <= hit_nx;
        r_any_q <= any_nx;
        r_off_q <= hit_nx ? hint_q : early_nx;
      end
    end
  end

  logic            m_valid_q, o_found_q, o_hint_q;
  logic [CntW-1:0] o_addr_q, o_off_q;

  assign out_free = !m_valid_q || m_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      o_found_q <= 1'b0;
      o_hint_q  <= 1'b0;
      o_addr_q  <= '0;
      o_off_q   <= '0;
    end else if (out_free) begin
      m_valid_q <= r_valid_q;
      if (r_valid_q) begin
        o_found_q <= r_hit_q || r_any_q;
        o_hint_q  <= r_hit_q;
        o_addr_q  <= (r_hit_q || r_any_q) ? base_q + r_off_q : '0;
        o_off_q   <= (!r_hit_q && r_any_q) ? r_off_q : '0;
      end
    end
  end

  assign m_tvalid = m_valid_q;
  assign m_tdata  = {(OutDataW - 2 - 2*CntW)'(0), o_off_q, o_hint_q, o_addr_q, o_found_q};

endmodule

// ----- hw/rtl/mbps_checker.sv -----
// ----------------------------------------------------------------------------
// Masked byte pattern scanner checker
// Port-level checks on the result words of the scanner.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbps_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [mbps_pkg::OutDataW-1:0] m_tdata
);

  import mbps_pkg::*;

  `ASSERT_RST(a_out_hold, clk_i, rst_ni, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result word changed while stalled")
  `ASSERT_IMPLY(a_not_found_zero, clk_i, rst_ni, m_tvalid && !m_tdata[0], m_tdata[2*CntW+1:1] == '0, "not-found word carries nonzero fields")
  `ASSERT_IMPLY(a_hint_found, clk_i, rst_ni, m_tvalid && m_tdata[CntW+1], m_tdata[0] && (m_tdata[2*CntW+1:CntW+2] == '0), "hint word without found or with an offset")

endmodule

bind masked_byte_pattern_scanner_unit mbps_checker u_mbps_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- bench/mbps_scan_checker.sv -----
// ----------------------------------------------------------------------------
// Scanner result checker
// Follows the register writes and the image words taken by the scanner,
// predicts the report of every image, and compares each report word that
// leaves the scanner against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module mbps_scan_checker
  import mbps_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [7:0]          s_tdata,
  input  logic                s_tlast,
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [OutDataW-1:0] m_tdata,
  input  logic                drain_done_i,
  output int unsigned         error_count_o
);

  typedef struct packed {
    logic [CntW-1:0] first_offset;
    logic            hint_correct;
    logic [CntW-1:0] match_address;
    logic            found;
  } scan_report_t;

  localparam int unsigned ReportW = $bits(scan_report_t);

  logic [CntW-1:0]     base_q;
  logic [LenW-1:0]     length_q;
  logic [CntW-1:0]     wild_q;
  logic [CntW-1:0]     hint_q;
  logic [CfgDataW-1:0] pattern_q [PatWords];
  logic [7:0]          window_q [MaxPattern];
  logic [CntW-1:0]     seen_q;
  logic [CntW-1:0]     earliest_q;
  logic                hint_hit_q;
  logic                any_hit_q;
  scan_report_t        awaited_reports [$];
  bit                  leftovers_done;

  function automatic int unsigned active_length();
    if (length_q == '0) return 1;
    if (length_q > MaxPattern) return MaxPattern;
    return length_q;
  endfunction

  function automatic logic [7:0] pattern_byte(int unsigned j);
    return pattern_q[j / 8][(j % 8) * 8 +: 8];
  endfunction

  function automatic bit window_hit(int unsigned n);
    for (int unsigned j = 0; j < n; j++) begin
      if (!wild_q[j] && window_q[n - 1 - j] != pattern_byte(j)) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic clear_scan();
    foreach (window_q[k]) window_q[k] = '0;
    seen_q     = '0;
    earliest_q = '0;
    hint_hit_q = 1'b0;
    any_hit_q  = 1'b0;
  endtask

  task automatic apply_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    case (idx)
      CfgBase:     base_q   = val[CntW-1:0];
      CfgLength:   length_q = val[LenW-1:0];
      CfgWildcard: wild_q   = val[CntW-1:0];
      CfgHint:     hint_q   = val[CntW-1:0];
      CfgPattern0, CfgPattern1, CfgPattern2, CfgPattern3: pattern_q[idx - CfgPattern0] = val;
      default: ;
    endcase
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic last);
    int unsigned     n;
    logic [CntW-1:0] off;
    scan_report_t    rep;
    n = active_length();
    // A saturated byte count opens no further window positions.
    if (seen_q != '1) begin
      for (int k = MaxPattern - 1; k > 0; k--) window_q[k] = window_q[k - 1];
      window_q[0] = b;
      seen_q++;
      if (seen_q >= n) begin
        off = seen_q - n;
        if (window_hit(n)) begin
          if (hint_q != NoHint && off == hint_q) hint_hit_q = 1'b1;
          if (!any_hit_q) begin
            any_hit_q  = 1'b1;
            earliest_q = off;
          end
        end
      end
    end
    if (last) begin
      rep = '0;
      if (hint_hit_q) begin
        rep.found         = 1'b1;
        rep.match_address = base_q + hint_q;
        rep.hint_correct  = 1'b1;
      end else if (any_hit_q) begin
        rep.found         = 1'b1;
        rep.match_address = base_q + earliest_q;
        rep.first_offset  = earliest_q;
      end
      awaited_reports = {awaited_reports, rep};
      clear_scan();
    end
  endtask

  task automatic flag(input string field, input logic [CntW-1:0] want,
                      input logic [CntW-1:0] got);
    error_count_o++;
    if (error_count_o <= 10) begin
      $display("%0t: report field %s: expected %h, got %h", $realtime, field, want, got);
    end
  endtask

  task automatic check_word(input logic [OutDataW-1:0] word);
    scan_report_t want;
    scan_report_t got;
    got = word[ReportW-1:0];
    if (awaited_reports.size() == 0) begin
      error_count_o++;
      if (error_count_o <= 10) begin
        $display("%0t: report word %h with no image pending", $realtime, word);
      end
      return;
    end
    want = awaited_reports.pop_front();
    if (got.found !== want.found) flag("found", want.found, got.found);
    if (got.match_address !== want.match_address) begin
      flag("match_address", want.match_address, got.match_address);
    end
    if (got.hint_correct !== want.hint_correct) begin
      flag("hint_correct", want.hint_correct, got.hint_correct);
    end
    if (got.first_offset !== want.first_offset) begin
      flag("first_match_offset", want.first_offset, got.first_offset);
    end
    if (word[OutDataW-1:ReportW] !== '0) flag("padding", '0, word[OutDataW-1:ReportW]);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      base_q        = '0;
      length_q      = LenW'(1);
      wild_q        = '0;
      hint_q        = NoHint;
      foreach (pattern_q[w]) pattern_q[w] = '0;
      clear_scan();
      awaited_reports.delete();
      leftovers_done = 1'b0;
      error_count_o  = 0;
    end else begin
      if (cfg_we_i) apply_write(cfg_idx_i, cfg_data_i);
      if (s_tvalid && s_tready) absorb_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) check_word(m_tdata);
      if (drain_done_i && !leftovers_done) begin
        leftovers_done = 1'b1;
        if (awaited_reports.size() != 0) begin
          $display("%0t: %0d image reports never arrived", $realtime,
                   awaited_reports.size());
          error_count_o += awaited_reports.size();
        end
      end
    end
  end

endmodule

// ----- bench/masked_byte_pattern_scanner_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Masked byte pattern scanner testbench
// Streams images into the scanner with random gaps and sink stalls, first a
// few directed images for the corner cases, then random register settings
// with images that carry planted, hinted and damaged copies of the pattern.
// A separate checker predicts and compares every report word.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_unit_tb;
  import mbps_pkg::*;

  localparam int unsigned ImageBytes   = 450;
  localparam int unsigned MinImages    = 40;
  localparam int unsigned SettleCycles = 8;
  localparam logic [CfgIdxW-1:0] SpareIdxLo = 4'd8;
  localparam logic [CfgIdxW-1:0] SpareIdxHi = 4'd15;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_tvalid   = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata    = '0;
  logic                s_tlast    = 1'b0;
  logic                m_tvalid;
  logic                m_tready   = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                drain_done = 1'b0;
  int unsigned         error_count;

  bit          src_rush    = 1'b0;
  bit          sink_rush   = 1'b0;
  logic        sink_took   = 1'b0;
  int unsigned sink_hold   = 0;
  int unsigned images_sent = 0;
  int unsigned words_taken = 0;
  int unsigned bytes_sent  = 0;

  int unsigned         eff_len = 1;
  logic [CntW-1:0]     wild_bits = '0;
  logic [CntW-1:0]     hint_at = NoHint;
  logic [CfgDataW-1:0] pat_words [PatWords] = '{default: '0};
  logic [7:0]          image [64];

  always #5 clk_i = ~clk_i;

  masked_byte_pattern_scanner_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  mbps_scan_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .drain_done_i  (drain_done),
    .error_count_o (error_count)
  );

  always @(posedge clk_i) begin
    sink_took <= m_tvalid && m_tready;
    if (m_tvalid && m_tready) words_taken <= words_taken + 1;
  end

  // The sink stalls for a fresh random count after every report word it takes.
  always @(negedge clk_i) begin
    if (sink_took) begin
      sink_hold = sink_rush ? 0 : $urandom_range(0, 9);
    end else if (sink_hold != 0) begin
      sink_hold--;
    end
    m_tready <= (sink_hold == 0);
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CfgLength: begin
        if (val[LenW-1:0] == '0) eff_len = 1;
        else if (val[LenW-1:0] > MaxPattern) eff_len = MaxPattern;
        else eff_len = val[LenW-1:0];
      end
      CfgWildcard: wild_bits = val[CntW-1:0];
      CfgHint:     hint_at   = val[CntW-1:0];
      CfgPattern0, CfgPattern1, CfgPattern2, CfgPattern3: pat_words[idx - CfgPattern0] = val;
      default: ;
    endcase
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = src_rush ? 0 : $urandom_range(0, 9);
    @(negedge clk_i);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk_i); while (!s_tready);
    bytes_sent++;
    if (last) images_sent++;
  endtask

  task automatic send_image(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) push_byte(image[i], i == len - 1);
  endtask

  // Stops the stream and lets every pending report drain before a register write.
  task automatic settle();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (words_taken != images_sent) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic plant(input int unsigned spot);
    for (int unsigned j = 0; j < eff_len; j++) begin
      if (!wild_bits[j]) image[spot + j] = pat_words[j / 8][(j % 8) * 8 +: 8];
    end
  endtask

  task automatic random_image();
    int unsigned len;
    int unsigned spot;
    len = $urandom_range(1, eff_len + 8);
    for (int unsigned i = 0; i < len; i++) image[i] = $urandom_range(0, 255);
    if (len >= eff_len) begin
      if ($urandom_range(0, 9) < 6) plant($urandom_range(0, len - eff_len));
      if (hint_at <= len - eff_len && $urandom_range(0, 1) == 1) plant(hint_at);
      if ($urandom_range(0, 3) == 0) begin
        spot = $urandom_range(0, len - 1);
        image[spot] = image[spot] ^ (8'd1 << $urandom_range(0, 7));
      end
    end
    send_image(len);
  endtask

  task automatic random_setup();
    int unsigned         pick;
    logic [CfgDataW-1:0] val;
    pick = $urandom_range(0, 19);
    if (pick < 13) val = $urandom_range(1, 6);
    else if (pick < 17) val = $urandom_range(7, MaxPattern);
    else if (pick == 17) val = '0;
    else val = $urandom_range(MaxPattern + 1, 63);
    write_reg(CfgLength, {$urandom, 26'd0, val[LenW-1:0]});

    pick = $urandom_range(0, 3);
    if (pick == 0) val = '0;
    else if (pick == 1) val = '1;
    else val = {$urandom, $urandom};
    write_reg(CfgBase, val);

    pick = $urandom_range(0, 9);
    if (pick < 4) val = '0;
    else if (pick == 4) val = '1;
    else if (pick < 8) val = {$urandom, $urandom & $urandom};
    else val = {$urandom, $urandom};
    write_reg(CfgWildcard, val);

    pick = $urandom_range(0, 9);
    if (pick < 3) val = {$urandom, NoHint};
    else if (pick < 8) val = {$urandom, 32'($urandom_range(0, 12))};
    else if (pick == 8) val = {$urandom, $urandom};
    else val = {$urandom, NoHint - 32'd1};
    write_reg(CfgHint, val);

    for (int unsigned w = 0; w < PatWords; w++) begin
      pick = $urandom_range(0, 5);
      if (pick == 0) val = '0;
      else if (pick == 1) val = '1;
      else val = {$urandom, $urandom};
      write_reg(CfgPattern0 + w, val);
    end

    if ($urandom_range(0, 4) == 0) begin
      write_reg($urandom_range(SpareIdxLo, SpareIdxHi), {$urandom, $urandom});
    end
    src_rush  = ($urandom_range(0, 3) == 0);
    sink_rush = ($urandom_range(0, 3) == 0);
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Register defaults: one pattern byte of zero, no wildcard, no hint.
    image[0] = 8'hFF; image[1] = 8'h00;
    send_image(2);
    image[0] = 8'hA5;
    send_image(1);

    // Zero length acts as one; the hint beats an earlier match; address wraps.
    settle();
    write_reg(CfgBase, 64'hFFFF_FFFF_FFFF_FFFE);
    write_reg(CfgLength, '0);
    write_reg(CfgHint, 64'd2);
    write_reg(CfgPattern0, 64'h0123_4567_89AB_CDAB);
    image[0] = 8'h00; image[1] = 8'hAB; image[2] = 8'hAB; image[3] = 8'hFF;
    send_image(4);

    // Image shorter than the pattern, then a match at the final window position
    // with a wildcard byte and a hint past the end of the image.
    settle();
    write_reg(CfgLength, 64'd4);
    write_reg(CfgWildcard, 64'h2);
    write_reg(CfgHint, 64'd100);
    write_reg(CfgPattern0, 64'h0000_0000_8000_7F01);
    image[0] = 8'h01; image[1] = 8'h33; image[2] = 8'h00;
    send_image(3);
    image[0] = 8'hFF; image[1] = 8'h01; image[2] = 8'h55; image[3] = 8'h00;
    image[4] = 8'h80;
    send_image(5);

    // A write to an unused index is dropped; a length change mid-image takes
    // effect from the next word on.
    settle();
    write_reg(CfgHint, {32'd0, NoHint});
    write_reg(SpareIdxLo + 4'd1, '1);
    write_reg(CfgLength, 64'd2);
    write_reg(CfgWildcard, '0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h22, 1'b0);
    settle();
    write_reg(CfgLength, 64'd1);
    push_byte(8'h01, 1'b1);

    while (bytes_sent < ImageBytes || images_sent < MinImages) begin
      settle();
      random_setup();
      repeat ($urandom_range(3, 6)) random_image();
    end

    settle();
    src_rush  = 1'b0;
    @(negedge clk_i);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
